/* design/dcq_pkg.sv */
// Shared types and codes for the deadline callback queue.
package dcq_pkg;

	// Command codes as carried on the command port.
	typedef enum logic [2:0] {
		CMD_REGISTER = 3'd0,
		CMD_CANCEL   = 3'd1,
		CMD_IDLE     = 3'd2,
		CMD_EXPIRE   = 3'd3,
		CMD_FLUSH    = 3'd4
	} cmd_t;

	// Result event codes.
	localparam logic [3:0] EV_REGISTERED = 4'd0;
	localparam logic [3:0] EV_FULL       = 4'd1;
	localparam logic [3:0] EV_CANCELLED  = 4'd2;
	localparam logic [3:0] EV_NOT_FOUND  = 4'd3;
	localparam logic [3:0] EV_IDLE_FIRED = 4'd4;
	localparam logic [3:0] EV_NONE       = 4'd5;
	localparam logic [3:0] EV_TIMED_OUT  = 4'd6;
	localparam logic [3:0] EV_SCAN_DONE  = 4'd7;
	localparam logic [3:0] EV_FLUSH_DONE = 4'd8;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_RD_ORD,
		ST_RD_DL,
		ST_DECIDE,
		ST_FINISH
	} state_t;

endpackage

/* design/dcq_ram.sv */
// Simple dual-port synchronous RAM with registered read.
module dcq_ram #(
	parameter int DATA_BITS = 32,
	parameter int ENTRIES   = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  logic [DATA_BITS-1:0]       wdata,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output logic [DATA_BITS-1:0]       rdata
);

	logic [DATA_BITS-1:0] mem_q [ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* design/deadline_callback_queue_unit.sv */
// Top level: deadline queue sequencer around the order and deadline memories.
// Register reports full when the queue is full, else searches for a free slot.
// Cancel, idle, expire and flush walk the order list, reading the order entry
// then its deadline for each pending entry, then finish.
// Each result is registered and appears for one cycle; no stall.
// Reset empties the queue; memory contents are not cleared and need no pass.
module deadline_callback_queue_unit #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [31:0] now,
	input  logic [31:0] delay_seconds,
	input  logic [3:0]  handle,
	output logic        result_valid,
	output logic [3:0]  event_kind,
	output logic [3:0]  slot,
	output logic [31:0] next_deadline,
	output logic        last
);

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TB = TIME_BITS;

	dcq_pkg::state_t state_q, state_d;
	dcq_pkg::cmd_t   cmd_q;

	logic [CW-1:0] cnt_q, r_q, w_q;
	logic [SW-1:0] s_q, slot_q, first_q;
	logic [DEPTH-1:0] occ_q;
	logic [TB-1:0] now_q, dl_q, next_q;
	logic [3:0] handle_q;
	logic found_q;

	logic [TB-1:0] now_t, dly_t;
	logic [TB:0] sum;
	logic accept, drop, find_hit, in_decide;

	logic          ord_we, dl_we;
	logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic [TB-1:0] dl_rdata;

	logic       emit_d, last_d;
	logic [3:0] ev_d, sl_d;
	logic [31:0] nx_d;

	// Saturating deadline sum at the configured time width.
	assign now_t = TB'(now);
	assign dly_t = TB'(delay_seconds);
	assign sum   = {1'b0, now_t} + {1'b0, dly_t};

	assign accept = start && !busy;
	assign busy   = (state_q != dcq_pkg::ST_IDLE);

	// Order list and deadline memories.
	dcq_ram #(.DATA_BITS(SW), .ENTRIES(DEPTH)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	dcq_ram #(.DATA_BITS(TB), .ENTRIES(DEPTH)) u_deadline (
		.clk(clk), .we(dl_we), .waddr(s_q), .wdata(dl_q),
		.raddr(ord_rdata), .rdata(dl_rdata)
	);

	// Entry removal test for the walking commands.
	always_comb begin
		unique case (cmd_q)
			dcq_pkg::CMD_CANCEL: drop = (8'(handle_q) == 8'(slot_q));
			dcq_pkg::CMD_IDLE:   drop = (r_q == '0);
			dcq_pkg::CMD_EXPIRE: drop = (dl_rdata <= now_q);
			default:             drop = 1'b1;
		endcase
	end

	assign find_hit  = (state_q == dcq_pkg::ST_FIND) && !occ_q[s_q];
	assign in_decide = (state_q == dcq_pkg::ST_DECIDE);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory control and result formation.
	always_comb begin
		state_d   = state_q;
		ord_we    = 1'b0;
		ord_waddr = w_q[SW-1:0];
		ord_wdata = slot_q;
		ord_raddr = r_q[SW-1:0];
		dl_we     = 1'b0;
		emit_d    = 1'b0;
		ev_d      = dcq_pkg::EV_REGISTERED;
		sl_d      = 4'd0;
		nx_d      = 32'd0;
		last_d    = 1'b0;
		unique case (state_q)
			dcq_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (command == dcq_pkg::CMD_REGISTER) begin
						if (cnt_q >= CW'(DEPTH)) begin
							emit_d = 1'b1;
							ev_d   = dcq_pkg::EV_FULL;
							last_d = 1'b1;
						end else begin
							state_d = dcq_pkg::ST_FIND;
						end
					end else if (command == dcq_pkg::CMD_CANCEL || command == dcq_pkg::CMD_IDLE
							|| command == dcq_pkg::CMD_EXPIRE
							|| command == dcq_pkg::CMD_FLUSH) begin
						state_d = dcq_pkg::ST_RD_ORD;
					end else begin
						state_d = dcq_pkg::ST_IDLE;
					end
				end
			end
			dcq_pkg::ST_FIND: begin
				if (find_hit) begin
					dl_we     = 1'b1;
					ord_we    = 1'b1;
					ord_waddr = cnt_q[SW-1:0];
					ord_wdata = s_q;
					emit_d    = 1'b1;
					ev_d      = dcq_pkg::EV_REGISTERED;
					sl_d      = 4'(s_q);
					last_d    = 1'b1;
					state_d   = dcq_pkg::ST_IDLE;
				end
			end
			dcq_pkg::ST_RD_ORD: begin
				state_d = (r_q == cnt_q) ? dcq_pkg::ST_FINISH : dcq_pkg::ST_RD_DL;
			end
			dcq_pkg::ST_RD_DL: begin
				state_d = dcq_pkg::ST_DECIDE;
			end
			dcq_pkg::ST_DECIDE: begin
				if (drop) begin
					if (cmd_q == dcq_pkg::CMD_EXPIRE) begin
						emit_d = 1'b1;
						ev_d   = dcq_pkg::EV_TIMED_OUT;
						sl_d   = 4'(slot_q);
					end else if (cmd_q == dcq_pkg::CMD_FLUSH) begin
						emit_d = 1'b1;
						ev_d   = dcq_pkg::EV_CANCELLED;
						sl_d   = 4'(slot_q);
					end
				end else begin
					ord_we = 1'b1;
				end
				state_d = dcq_pkg::ST_RD_ORD;
			end
			dcq_pkg::ST_FINISH: begin
				emit_d  = 1'b1;
				last_d  = 1'b1;
				state_d = dcq_pkg::ST_IDLE;
				unique case (cmd_q)
					dcq_pkg::CMD_CANCEL: begin
						ev_d = found_q ? dcq_pkg::EV_CANCELLED : dcq_pkg::EV_NOT_FOUND;
						sl_d = handle_q;
					end
					dcq_pkg::CMD_IDLE: begin
						ev_d = found_q ? dcq_pkg::EV_IDLE_FIRED : dcq_pkg::EV_NONE;
						sl_d = found_q ? 4'(first_q) : 4'd0;
					end
					dcq_pkg::CMD_EXPIRE: begin
						ev_d = dcq_pkg::EV_SCAN_DONE;
						nx_d = 32'(next_q);
					end
					default: ev_d = dcq_pkg::EV_FLUSH_DONE;
				endcase
			end
			default: state_d = dcq_pkg::ST_IDLE;
		endcase
	end

	// Queue control state: count, occupancy and walk pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			occ_q   <= '0;
			r_q     <= '0;
			w_q     <= '0;
			s_q     <= '0;
			found_q <= 1'b0;
			cmd_q   <= dcq_pkg::CMD_REGISTER;
		end else begin
			if (accept) begin
				cmd_q   <= dcq_pkg::cmd_t'(command);
				r_q     <= '0;
				w_q     <= '0;
				s_q     <= '0;
				found_q <= 1'b0;
			end
			if (state_q == dcq_pkg::ST_FIND) begin
				if (find_hit) begin
					occ_q[s_q] <= 1'b1;
					cnt_q      <= cnt_q + CW'(1);
				end else begin
					s_q <= s_q + SW'(1);
				end
			end
			if (in_decide) begin
				r_q <= r_q + CW'(1);
				if (drop) begin
					occ_q[slot_q] <= 1'b0;
					found_q       <= 1'b1;
				end else begin
					w_q <= w_q + CW'(1);
				end
			end
			if (state_q == dcq_pkg::ST_FINISH) begin
				cnt_q <= w_q;
			end
		end
	end

	// Command operands and walk data.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= now_t;
			dl_q     <= sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
			handle_q <= handle;
			next_q   <= '0;
		end
		if (state_q == dcq_pkg::ST_RD_DL) begin
			slot_q <= ord_rdata;
		end
		if (in_decide) begin
			if (drop && r_q == '0) begin
				first_q <= slot_q;
			end
			if (!drop && (next_q == '0 || dl_rdata < next_q)) begin
				next_q <= dl_rdata;
			end
		end
	end

	// Result registers: valid is control, the fields are payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		event_kind    <= ev_d;
		slot          <= sl_d;
		next_deadline <= nx_d;
		last          <= last_d;
	end

	// Occupancy agrees with the pending count whenever the queue is at rest.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dcq_pkg::ST_IDLE) |-> ($countones(occ_q) == int'(cnt_q)))
		else $error("occupancy map and pending count disagree");

	// Compaction write pointer never overtakes the read pointer.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (w_q <= r_q && r_q <= cnt_q))
		else $error("walk pointers out of order");

	// The pending count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("pending count beyond depth");

	// A final result always closes the command, so the unit is free again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_d && last_d) |=> !busy)
		else $error("unit still busy after final result");

endmodule
